// ===== hdl/lzw_variable_width_decoder_macros.svh =====
// Assertion helpers for the decoder source.
`ifndef LZW_VARIABLE_WIDTH_DECODER_MACROS_SVH
`define LZW_VARIABLE_WIDTH_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LVWD_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("lvwd check failed");

// Next-cycle implication, checked outside reset.
`define LVWD_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("lvwd check failed");

`endif

// ===== hdl/lvwd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lvwd_pkg;
  localparam int MAX_CODE_BITS = 12;
  localparam int DICT_AW       = 12;
  localparam int DICT_DEPTH    = 4096;
  localparam int STRING_MAX    = 255;
  localparam int STACK_AW      = 8;

  localparam logic [11:0] CODE_CLEAR  = 12'h100;
  localparam logic [11:0] CODE_END    = 12'h101;
  localparam logic [12:0] FIRST_FREE  = 13'h102;
  localparam logic [12:0] FIRST_LIMIT = 13'h200;

  typedef struct packed {
    logic [11:0] prefix;
    logic [7:0]  suffix;
  } dict_entry_t;

  typedef struct packed {
    logic                en;
    logic [DICT_AW-1:0]  addr;
    dict_entry_t         entry;
  } dict_wr_t;

  typedef struct packed {
    logic                en;
    logic [STACK_AW-1:0] addr;
    logic [7:0]          data;
  } stk_wr_t;
endpackage
`default_nettype wire

// ===== hdl/lzw_variable_width_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Payload
// s_*      in   tdata[7:0] in_byte
// m_*      out  tdata[63:0] out_bytes, [67:64] out_count; tlast out_last;
//               tuser[0] out_end, [1] out_overflow
// One byte per transaction; a byte that completes no code only fills the accumulator.
// A data code walks its prefix links through the dictionary, then reads its
// bytes back from the reverse stack into results, then writes the new
// dictionary entry.
// rst is synchronous; no clearing pass, the memories start undefined.
// A stalled m_tready holds the output register and halts the decode.
module lzw_variable_width_decoder import lvwd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // in_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // out_bytes[63:0], out_count[67:64], zero pad
  output logic             m_tlast,   // out_last
  output logic [1:0]       m_tuser    // out_end, out_overflow
);
  `include "lzw_variable_width_decoder_macros.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_DAT  = 3'd2;
  localparam logic [2:0] ST_SRD  = 3'd3;
  localparam logic [2:0] ST_SDAT = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;
  localparam logic [2:0] ST_WR   = 3'd6;

  logic [2:0]  state;
  logic [19:0] acc;
  logic [4:0]  held;
  logic [3:0]  code_width;
  logic [12:0] next_free;
  logic [12:0] width_limit;
  logic [11:0] prev_code;
  logic [7:0]  prev_first;
  logic        clear_pending;
  logic        stream_done;
  logic [11:0] code_r;
  logic [11:0] cur;
  logic [12:0] steps;
  logic [8:0]  n;
  logic [8:0]  r;
  logic [2:0]  j;
  logic        ovf;
  logic [7:0]  root;
  logic [63:0] word;
  logic [3:0]  cnt;
  logic        lastf;
  logic        endf;
  logic        do_wr;

  dict_wr_t    dwr;
  dict_entry_t ddout;
  stk_wr_t     swr;
  logic [7:0]  sdout;
  logic [8:0]  srd;

  logic [19:0] acc_new;
  logic [4:0]  held_new;
  logic [11:0] code;
  logic [7:0]  push_data;
  logic        push;
  logic        can_load;
  logic        load;
  logic [12:0] nf_inc;

  lvwd_dict u_dict (.clk(clk), .wr(dwr), .rd_addr(cur), .rd_data(ddout));
  lvwd_stack u_stack (.clk(clk), .wr(swr), .rd_addr(srd[STACK_AW-1:0]), .rd_data(sdout));

  assign s_tready = (state == ST_IDLE);
  assign can_load = !m_tvalid || m_tready;
  assign load     = (state == ST_OUT) && can_load;

  // Unpack the next code from the accumulator; also form the stack read address and next free code
  always_comb begin
    acc_new  = acc | (20'(s_tdata) << held);
    held_new = held + 5'd8;
    code     = 12'(acc_new & ((20'd1 << code_width) - 20'd1));
    srd      = n - 9'd1 - r;
    nf_inc   = next_free + ((next_free < 13'(DICT_DEPTH)) ? 13'd1 : 13'd0);
  end

  // Select the byte pushed onto the reverse stack and drive the dictionary write
  always_comb begin
    push      = 1'b0;
    push_data = ddout.suffix;
    unique case (state)
      ST_IDLE: begin
        push      = s_tvalid && !stream_done && (held_new >= 5'(code_width)) &&
                    !clear_pending && (code != CODE_END) && (code != CODE_CLEAR) &&
                    ({1'b0, code} >= next_free);
        push_data = prev_first;
      end
      ST_CHK: begin
        push      = !((cur > 12'hFF) && (steps < 13'(DICT_DEPTH)));
        push_data = cur[7:0];
      end
      ST_DAT: begin
        push      = 1'b1;
        push_data = ddout.suffix;
      end
      default: begin
        push      = 1'b0;
        push_data = ddout.suffix;
      end
    endcase
    // A new string starts at the bottom of the stack
    swr.en   = push && ((state == ST_IDLE) || (n < 9'(STRING_MAX)));
    swr.addr = (state == ST_IDLE) ? '0 : n[STACK_AW-1:0];
    swr.data = push_data;
    dwr.en          = (state == ST_WR) && (next_free < 13'(DICT_DEPTH));
    dwr.addr        = next_free[DICT_AW-1:0];
    dwr.entry.prefix = prev_code;
    dwr.entry.suffix = root;
  end

  // Sequence data codes through walk, emit and dictionary update; handle clear and end codes
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      acc           <= '0;
      held          <= '0;
      code_width    <= 4'd9;
      next_free     <= FIRST_FREE;
      width_limit   <= FIRST_LIMIT;
      prev_code     <= '0;
      prev_first    <= '0;
      clear_pending <= 1'b0;
      stream_done   <= 1'b0;
      m_tvalid      <= 1'b0;
      n             <= '0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && !stream_done) begin
            if (held_new < 5'(code_width)) begin
              acc  <= acc_new;
              held <= held_new;
            end else begin
              acc    <= acc_new >> code_width;
              held   <= held_new - 5'(code_width);
              code_r <= code;
              lastf  <= 1'b1;
              endf   <= 1'b0;
              ovf    <= 1'b0;
              do_wr  <= 1'b0;
              if (clear_pending) begin
                clear_pending <= 1'b0;
                prev_code     <= code;
                prev_first    <= code[7:0];
                word          <= {56'd0, code[7:0]};
                cnt           <= 4'd1;
                state         <= ST_OUT;
              end else if (code == CODE_END) begin
                stream_done <= 1'b1;
                endf        <= 1'b1;
                word        <= '0;
                cnt         <= 4'd0;
                state       <= ST_OUT;
              end else if (code == CODE_CLEAR) begin
                code_width    <= 4'd9;
                next_free     <= FIRST_FREE;
                width_limit   <= FIRST_LIMIT;
                clear_pending <= 1'b1;
                word          <= '0;
              end else begin
                do_wr <= 1'b1;
                steps <= '0;
                word  <= '0;
                if ({1'b0, code} >= next_free) begin
                  n   <= 9'd1;
                  cur <= prev_code;
                end else begin
                  n   <= 9'd0;
                  cur <= code;
                end
                state <= ST_CHK;
              end
            end
          end
        end
        ST_CHK: begin
          if ((cur > 12'hFF) && (steps < 13'(DICT_DEPTH))) begin
            state <= ST_DAT;
          end else begin
            if (swr.en) begin
              n <= n + 9'd1;
            end
            if ((cur > 12'hFF) || !swr.en) begin
              ovf <= 1'b1;
            end
            root  <= cur[7:0];
            r     <= '0;
            j     <= '0;
            state <= ST_SRD;
          end
        end
        ST_DAT: begin
          if (swr.en) begin
            n <= n + 9'd1;
          end else begin
            ovf <= 1'b1;
          end
          cur   <= ddout.prefix;
          steps <= steps + 13'd1;
          state <= ST_CHK;
        end
        ST_SRD: begin
          state <= ST_SDAT;
        end
        ST_SDAT: begin
          word[j*8 +: 8] <= sdout;
          r <= r + 9'd1;
          j <= j + 3'd1;
          if ((r + 9'd1 == n) || (j == 3'd7)) begin
            cnt   <= 4'(j) + 4'd1;
            lastf <= (r + 9'd1 == n);
            state <= ST_OUT;
          end else begin
            state <= ST_SRD;
          end
        end
        ST_OUT: begin
          if (can_load) begin
            m_tdata  <= {4'd0, cnt, word};
            m_tlast  <= lastf;
            m_tuser  <= {ovf, endf};
            if (lastf) begin
              state <= do_wr ? ST_WR : ST_IDLE;
            end else begin
              word  <= '0;
              j     <= '0;
              state <= ST_SRD;
            end
          end
        end
        ST_WR: begin
          next_free  <= nf_inc;
          prev_code  <= code_r;
          prev_first <= root;
          if ((nf_inc >= width_limit) && (code_width < 4'(MAX_CODE_BITS))) begin
            code_width  <= code_width + 4'd1;
            width_limit <= width_limit << 1;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `LVWD_ASSERT_IMPL(a_end_shape, m_tvalid && m_tuser[0], m_tlast && (m_tdata[67:64] == 4'd0))
  `LVWD_ASSERT_IMPL(a_data_count, m_tvalid && !m_tuser[0], m_tdata[67:64] != 4'd0)
  `LVWD_ASSERT_IMPL(a_stack_bound, 1'b1, n <= 9'(STRING_MAX))
  `LVWD_ASSERT_IMPL(a_width_range, 1'b1, (code_width >= 4'd9) && (code_width <= 4'(MAX_CODE_BITS)))
  `LVWD_ASSERT_NEXT(a_wr_return, state == ST_WR, state == ST_IDLE)
endmodule
`default_nettype wire

// ===== hdl/lvwd_dict.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lvwd_dict import lvwd_pkg::*; (
  input  wire logic              clk,
  input  wire dict_wr_t          wr,
  input  wire logic [DICT_AW-1:0] rd_addr,
  output dict_entry_t            rd_data
);
  dict_entry_t mem [DICT_DEPTH];

  // Write new entry; registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ===== hdl/lvwd_stack.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lvwd_stack import lvwd_pkg::*; (
  input  wire logic               clk,
  input  wire stk_wr_t            wr,
  input  wire logic [STACK_AW-1:0] rd_addr,
  output logic [7:0]              rd_data
);
  logic [7:0] mem [2**STACK_AW];

  // Push decoded bytes, read back in reverse order
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire
